// ===== src/pec15_pkg.sv =====
`default_nettype none

package pec15_pkg;

   // Remainder seed and CRC15 polynomial
   localparam logic [15:0] PEC_SEED = 16'd16;
   localparam logic [15:0] PEC_POLY = 16'h4599;

   // Result queue depth; must be at least two (an emit pushes two beats)
   localparam int RSP_DEPTH_DEFAULT = 4;

   // Command codes on req_cmd
   typedef enum logic [1:0] {
      CMD_PAYLOAD  = 2'd0,
      CMD_PEC_HIGH = 2'd1,
      CMD_PEC_LOW  = 2'd2,
      CMD_EMIT     = 2'd3
   } cmd_type;

   // Result kinds on rsp_out_kind
   localparam logic [1:0] KIND_ECHO  = 2'd0;
   localparam logic [1:0] KIND_PEC   = 2'd1;
   localparam logic [1:0] KIND_CHECK = 2'd2;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] out_kind;
      logic       pec_ok;
      logic       frame_last;
   } rsp_entry_type;

   // CRC15 table entry: eight shift/xor steps on a 16-bit value
   function automatic logic [15:0] pec_table_entry(input logic [7:0] addr);
      logic [15:0] r;
      r = {1'b0, addr, 7'b0};
      for (int i = 0; i < 8; i++) begin
         if (r[14]) begin
            r = {r[14:0], 1'b0} ^ PEC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/pec15_rsp_fifo.sv =====
`default_nettype none

module pec15_rsp_fifo #(
   parameter int DEPTH = pec15_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push0,
   input  logic                     push1,
   input  pec15_pkg::rsp_entry_type push0_entry,
   input  pec15_pkg::rsp_entry_type push1_entry,
   input  logic                     pop_ready,
   output logic                     pop_valid,
   output pec15_pkg::rsp_entry_type head,
   output logic                     room_two
);
   import pec15_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_entry_type    entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic             pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign pop         = pop_valid & pop_ready;
   assign pop_valid   = (count_ff != '0);
   assign head        = entries_ff[rd_ptr_ff];
   assign room_two    = (count_ff <= CNT_W'(DEPTH - 2));
   assign wr_ptr_next = next_ptr(wr_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push0 && push1) begin
         wr_ptr_in = next_ptr(wr_ptr_next);
      end else if (push0) begin
         wr_ptr_in = wr_ptr_next;
      end
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         entries_ff[wr_ptr_ff] <= push0_entry;
      end
      if (push1) begin
         entries_ff[wr_ptr_next] <= push1_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue overfilled");

   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push1 |-> push0)
      else $error("second push without first");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (push0 && !pop) |=> pop_valid)
      else $error("pushed beat not visible");

   a_no_overflow_push: assert property (@(posedge clock) disable iff (reset)
      (push0 && push1) |-> room_two)
      else $error("double push without room");

endmodule

`default_nettype wire

// ===== src/pec15_frame_generate_check.sv =====
`default_nettype none

// PEC15 frame engine for serial monitor byte streams. Each req beat carries a
// command and a byte: a payload byte folds into the 16-bit running remainder
// (seed 16, CRC15 polynomial 0x4599, one table step per byte) and is echoed on
// rsp; a received PEC high byte is compared against the current PEC and
// remembered, giving no result; a received PEC low byte completes the check
// and returns one check beat (pec_ok high only when both bytes matched,
// frame_last high); an emit returns the PEC (remainder shifted left by one)
// as two beats, high byte then low byte, frame_last on the low one. After an
// emit or a check the remainder goes back to its seed and any stored high-byte
// match is dropped. A req beat is taken every cycle req_ready is high: the
// remainder update is a single table step and XOR between the input handshake
// and the remainder register. Results pass through an RSP_DEPTH-entry queue;
// req_ready is high while at least two entries are free, so with rsp_ready held
// high the block sustains one req beat per cycle and one rsp beat per cycle,
// the rsp port (one beat per cycle) setting the pace when emits are frequent.

module pec15_frame_generate_check #(
   parameter int RSP_DEPTH = pec15_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_out_kind,
   output logic       rsp_pec_ok,
   output logic       rsp_frame_last
);
   import pec15_pkg::*;

   logic [15:0]   crc_remainder_ff, crc_remainder_in;
   logic          high_matched_ff, high_matched_in;
   logic          accept;
   logic [15:0]   pec;
   logic [7:0]    tbl_addr;
   logic [15:0]   tbl_entry;
   logic          push0, push1;
   rsp_entry_type push0_entry, push1_entry;
   rsp_entry_type head;
   cmd_type       cmd;

   assign accept    = req_valid & req_ready;
   assign cmd       = cmd_type'(req_cmd);
   // PEC is the remainder doubled, kept to 16 bits
   assign pec       = {crc_remainder_ff[14:0], 1'b0};
   assign tbl_addr  = crc_remainder_ff[14:7] ^ req_data_byte;
   assign tbl_entry = pec_table_entry(tbl_addr);

   always_comb begin
      crc_remainder_in = crc_remainder_ff;
      high_matched_in  = high_matched_ff;
      push0            = 1'b0;
      push1            = 1'b0;
      push0_entry      = '{out_byte: req_data_byte, out_kind: KIND_ECHO,
                           pec_ok: 1'b0, frame_last: 1'b0};
      push1_entry      = '{out_byte: pec[7:0], out_kind: KIND_PEC,
                           pec_ok: 1'b0, frame_last: 1'b1};
      if (accept) begin
         case (cmd)
            CMD_PAYLOAD: begin
               crc_remainder_in = {crc_remainder_ff[7:0], 8'h00} ^ tbl_entry;
               push0            = 1'b1;
            end
            CMD_PEC_HIGH: begin
               // latest high byte replaces any earlier comparison
               high_matched_in = (pec[15:8] == req_data_byte);
            end
            CMD_PEC_LOW: begin
               push0            = 1'b1;
               push0_entry      = '{out_byte: 8'h00, out_kind: KIND_CHECK,
                                    pec_ok: high_matched_ff &&
                                            (pec[7:0] == req_data_byte),
                                    frame_last: 1'b1};
               crc_remainder_in = PEC_SEED;
               high_matched_in  = 1'b0;
            end
            CMD_EMIT: begin
               push0            = 1'b1;
               push1            = 1'b1;
               push0_entry      = '{out_byte: pec[15:8], out_kind: KIND_PEC,
                                    pec_ok: 1'b0, frame_last: 1'b0};
               crc_remainder_in = PEC_SEED;
               high_matched_in  = 1'b0;
            end
            default: begin
               crc_remainder_in = crc_remainder_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_remainder_ff <= PEC_SEED;
         high_matched_ff  <= 1'b0;
      end else begin
         crc_remainder_ff <= crc_remainder_in;
         high_matched_ff  <= high_matched_in;
      end
   end

   pec15_rsp_fifo #(
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push0      (push0),
      .push1      (push1),
      .push0_entry(push0_entry),
      .push1_entry(push1_entry),
      .pop_ready  (rsp_ready),
      .pop_valid  (rsp_valid),
      .head       (head),
      .room_two   (req_ready)
   );

   assign rsp_out_byte   = head.out_byte;
   assign rsp_out_kind   = head.out_kind;
   assign rsp_pec_ok     = head.pec_ok;
   assign rsp_frame_last = head.frame_last;

   // emit or check ends the frame: remainder back to seed, match dropped
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_EMIT || req_cmd == CMD_PEC_LOW)) |=>
      (crc_remainder_ff == PEC_SEED && !high_matched_ff))
      else $error("remainder not reseeded after frame end");

   // a received PEC high byte never touches the remainder
   a_high_keeps_crc: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_PEC_HIGH) |=> $stable(crc_remainder_ff))
      else $error("PEC high byte changed remainder");

   // any result-producing beat leaves rsp_valid high next cycle
   a_result_visible: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd != CMD_PEC_HIGH) |=> rsp_valid)
      else $error("result beat missing");

endmodule

`default_nettype wire
